// ===== rtl/pol_pkg.sv =====
// Package for the positional ordered list: codes, result layout and shared types.
`timescale 1ns / 1ps

package pol_pkg;

  // Fixed field widths
  localparam int unsigned POS_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  // End marker for neighbor positions (-1 in 7 bits)
  localparam logic signed [POS_W-1:0] POS_NONE = 7'sh7F;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    POL_IDLE   = 2'd0,
    POL_ROTATE = 2'd1,
    POL_DRAIN  = 2'd2
  } state_e;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

  // Result item, laid out as it travels on the output tdata (lowest field last)
  typedef struct packed {
    logic [6:0]              pad;
    logic                    is_full;
    logic                    is_empty;
    logic signed [POS_W-1:0] next_pos;
    logic signed [POS_W-1:0] prev_pos;
    logic [POS_W-1:0]        count_after;
    logic [WORD_W-1:0]       entry_out;
    status_e                 status;
  } result_t;

endpackage

// ===== rtl/positional_ordered_list.sv =====
// Top level of the positional ordered list: a row of entry cells under one controller.
// Insert, remove, clear and failed requests: result registered in the cycle after accept,
//   one request per cycle while the result is taken.
// Successful read: one full rotation of the cell row past cell 0 captures the entry,
//   then the result register is loaded once the output is free; no request is
//   taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result;
//   entry words are not cleared.
`timescale 1ns / 1ps

module positional_ordered_list #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[6:0], entry_in[38:7], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], entry_out[33:2], count_after[40:34], prev_pos[47:41],
  // next_pos[54:48], is_empty[55], is_full[56], zero pad
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned SW = (ENTRY_WIDTH < pol_pkg::WORD_W) ? ENTRY_WIDTH
                                                               : pol_pkg::WORD_W;

  pol_pkg::cell_ctrl_t cell_ctrl;
  pol_pkg::result_t    result;
  logic [SW-1:0]       cell_data [CAPACITY];
  logic [SW-1:0]       word;
  logic [pol_pkg::POS_W-1:0] in_pos;

  // Unpack the request
  assign in_pos = s_axis_tdata[6:0];
  assign word   = SW'(s_axis_tdata[38:7]);

  pol_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (pol_pkg::kind_e'(s_axis_tuser)),
    .in_pos_i    (in_pos),
    .cell0_i     (cell_data[0]),
    .cell_ctrl_o (cell_ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  // Row of cells, closed into a ring for rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pol_cell #(
      .IDX (i),
      .SW  (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .left_i  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_data[(i + 1) % CAPACITY]),
      .word_i  (word),
      .data_o  (cell_data[i])
    );
  end

  assign m_axis_tdata = result;

endmodule

// ===== rtl/pol_cell.sv =====
// One list cell: holds the entry at its position and trades it with its neighbors.
`timescale 1ns / 1ps

module pol_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 32
) (
  input  logic                clk_i,
  input  pol_pkg::cell_ctrl_t ctrl_i,
  input  logic [SW-1:0]       left_i,
  input  logic [SW-1:0]       right_i,
  input  logic [SW-1:0]       word_i,
  output logic [SW-1:0]       data_o
);

  logic [SW-1:0] data_q;
  logic [SW-1:0] data_d;
  logic          at_pos;
  logic          past_pos;

  // Locate this cell relative to the addressed position
  assign at_pos   = (32'(ctrl_i.pos) == 32'(IDX));
  assign past_pos = (32'(ctrl_i.pos) <  32'(IDX));

  // Pick the new content: shift up on insert, shift down on remove, circulate on rotate
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      pol_pkg::CELL_HOLD: begin
        data_d = data_q;
      end
      pol_pkg::CELL_INSERT: begin
        if (at_pos) begin
          data_d = word_i;
        end else if (past_pos) begin
          data_d = left_i;
        end
      end
      pol_pkg::CELL_REMOVE: begin
        if (at_pos || past_pos) begin
          data_d = right_i;
        end
      end
      pol_pkg::CELL_ROTATE: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/pol_ctrl.sv =====
// Request control: occupancy, status and neighbor logic, read rotation and result register.
`timescale 1ns / 1ps

module pol_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned SW       = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pol_pkg::kind_e         in_kind_i,
  input  logic [pol_pkg::POS_W-1:0] in_pos_i,
  input  logic [SW-1:0]          cell0_i,
  output pol_pkg::cell_ctrl_t    cell_ctrl_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pol_pkg::result_t       out_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned STW  = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W;

  pol_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [STW-1:0]   step_q, step_d;
  logic [pol_pkg::POS_W-1:0] rd_pos_q, rd_pos_d;
  pol_pkg::result_t pend_q, pend_d;
  pol_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             out_free;
  logic             accept;
  logic [CMPW-1:0]  pos_x;
  logic [CMPW-1:0]  cnt_x;
  logic [CMPW-1:0]  cnt_new_x;
  logic [CW-1:0]    cnt_new;
  pol_pkg::status_e status;
  pol_pkg::cell_op_e op_sel;
  logic             go_read;
  logic             occupied;
  pol_pkg::result_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == pol_pkg::POL_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_x = CMPW'(in_pos_i);
  assign cnt_x = CMPW'(cnt_q);

  // Decode the request against the current occupancy
  always_comb begin
    status  = pol_pkg::STAT_OK;
    cnt_new = cnt_q;
    op_sel  = pol_pkg::CELL_HOLD;
    go_read = 1'b0;
    unique case (in_kind_i)
      pol_pkg::KIND_INSERT: begin
        if (cnt_q == CW'(CAPACITY)) begin
          status = pol_pkg::STAT_FULL;
        end else if (pos_x > cnt_x) begin
          status = pol_pkg::STAT_BADPOS;
        end else begin
          cnt_new = cnt_q + CW'(1);
          op_sel  = pol_pkg::CELL_INSERT;
        end
      end
      pol_pkg::KIND_REMOVE: begin
        if (cnt_q == '0) begin
          status = pol_pkg::STAT_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = pol_pkg::STAT_BADPOS;
        end else begin
          cnt_new = cnt_q - CW'(1);
          op_sel  = pol_pkg::CELL_REMOVE;
        end
      end
      pol_pkg::KIND_READ: begin
        if (cnt_q == '0) begin
          status = pol_pkg::STAT_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = pol_pkg::STAT_BADPOS;
        end else begin
          go_read = 1'b1;
        end
      end
      pol_pkg::KIND_CLEAR: begin
        cnt_new = '0;
      end
      default: begin
        cnt_new = cnt_q;
      end
    endcase
  end

  // Build the result fields from the occupancy after the request
  assign cnt_new_x = CMPW'(cnt_new);
  assign occupied  = (pos_x < cnt_new_x);

  always_comb begin
    res             = '0;
    res.status      = status;
    res.entry_out   = '0;
    res.count_after = pol_pkg::POS_W'(cnt_new);
    res.prev_pos    = pol_pkg::POS_NONE;
    res.next_pos    = pol_pkg::POS_NONE;
    if (occupied && (in_pos_i != '0)) begin
      res.prev_pos = in_pos_i - pol_pkg::POS_W'(1);
    end
    if (occupied && ((pos_x + CMPW'(1)) != cnt_new_x)) begin
      res.next_pos = in_pos_i + pol_pkg::POS_W'(1);
    end
    res.is_empty = (cnt_new == '0);
    res.is_full  = (cnt_new == CW'(CAPACITY));
  end

  // Next state, cell command and result register
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    step_d           = step_q;
    rd_pos_d         = rd_pos_q;
    pend_d           = pend_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    cell_ctrl_o.op   = pol_pkg::CELL_HOLD;
    cell_ctrl_o.pos  = in_pos_i;
    unique case (state_q)
      pol_pkg::POL_IDLE: begin
        if (accept) begin
          cnt_d          = cnt_new;
          cell_ctrl_o.op = op_sel;
          if (go_read) begin
            pend_d   = res;
            rd_pos_d = in_pos_i;
            step_d   = '0;
            state_d  = pol_pkg::POL_ROTATE;
          end else begin
            out_d       = res;
            out_valid_d = 1'b1;
          end
        end
      end
      pol_pkg::POL_ROTATE: begin
        // Circulate the whole row once; grab cell 0 when the addressed entry passes
        cell_ctrl_o.op = pol_pkg::CELL_ROTATE;
        if (CMPW'(step_q) == CMPW'(rd_pos_q)) begin
          pend_d.entry_out = pol_pkg::WORD_W'(cell0_i);
        end
        step_d = step_q + STW'(1);
        if (step_q == STW'(CAPACITY - 1)) begin
          state_d = pol_pkg::POL_DRAIN;
        end
      end
      pol_pkg::POL_DRAIN: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = pol_pkg::POL_IDLE;
        end
      end
      default: begin
        state_d = pol_pkg::POL_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pol_pkg::POL_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/pol_checker.sv =====
// Port-level checks for the positional ordered list, bound to the top level.
`timescale 1ns / 1ps

module pol_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Empty flag follows the reported count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[55] == (m_axis_tdata[40:34] == 7'd0)))
    else $error("empty flag disagrees with count");

  // Never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[55] && m_axis_tdata[56]))
    else $error("full and empty both set");

  // A failed request returns no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != pol_pkg::STAT_OK)
      |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("entry returned on failed request");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
